@@ design/rme_pkg.sv @@
package rme_pkg;

	localparam int SQRT_STEPS   = 31;
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 36;

	localparam logic signed [CW-1:0] PI_Q30    = 36'sd3373259426;
	localparam logic signed [CW-1:0] ROUND_Q30 = 36'sd65536;
	localparam logic signed [15:0]   ANGLE_MAX = 16'sd25736;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} mat_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 spec;
		logic                 spec_pi;
	} lane_t;

	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic signed [CW-1:0] a;
		case (i)
			0:  a = 36'sh03243F6A8;
			1:  a = 36'sh01DAC6705;
			2:  a = 36'sh00FADBAFC;
			3:  a = 36'sh007F56EA6;
			4:  a = 36'sh003FEAB76;
			5:  a = 36'sh001FFD55B;
			6:  a = 36'sh000FFFAAA;
			7:  a = 36'sh0007FFF55;
			8:  a = 36'sh0003FFFEA;
			9:  a = 36'sh0001FFFFD;
			10: a = 36'sh0000FFFFF;
			11: a = 36'sh00007FFFF;
			12: a = 36'sh00003FFFF;
			13: a = 36'sh00001FFFF;
			14: a = 36'sh00000FFFF;
			15: a = 36'sh000007FFF;
			16: a = 36'sh000003FFF;
			17: a = 36'sh000001FFF;
			18: a = 36'sh000000FFF;
			19: a = 36'sh0000007FF;
			20: a = 36'sh0000003FF;
			21: a = 36'sh0000001FF;
			22: a = 36'sh0000000FF;
			23: a = 36'sh00000007F;
			24: a = 36'sh00000003F;
			25: a = 36'sh00000001F;
			26: a = 36'sh00000000F;
			27: a = 36'sh000000008;
			28: a = 36'sh000000004;
			29: a = 36'sh000000002;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic lane_t cordic_prep(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		lane_t l;
		l.spec    = (y == '0);
		l.spec_pi = x[CW-1];
		l.x       = x;
		l.y       = y;
		l.z       = '0;
		if (x[CW-1]) begin
			l.z = y[CW-1] ? -PI_Q30 : PI_Q30;
			l.x = -x;
			l.y = -y;
		end
		return l;
	endfunction

	function automatic lane_t cordic_step(input lane_t l, input int i);
		lane_t o;
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		xs = l.x >>> i;
		ys = l.y >>> i;
		o  = l;
		if (!l.y[CW-1]) begin
			o.x = l.x + ys;
			o.y = l.y - xs;
			o.z = l.z + atan_q30(i);
		end else begin
			o.x = l.x - ys;
			o.y = l.y + xs;
			o.z = l.z - atan_q30(i);
		end
		return o;
	endfunction

	function automatic logic signed [15:0] cordic_finish(input lane_t l);
		logic signed [CW-1:0] r;
		logic signed [15:0]   a;
		r = (l.z + ROUND_Q30) >>> 17;
		if (r > CW'(ANGLE_MAX))
			a = ANGLE_MAX;
		else if (r < -CW'(ANGLE_MAX))
			a = -ANGLE_MAX;
		else
			a = r[15:0];
		if (l.spec)
			a = l.spec_pi ? ANGLE_MAX : 16'sd0;
		return a;
	endfunction

endpackage

@@ design/rotation_matrix_to_euler.sv @@
// channel | direction | handshake         | word
// in      | input     | in_valid/in_stall | r00 r10 r11 r12 r20 r21 r22
// out     | output    | out_valid/out_stall | angle_x angle_y angle_z singular
// cfg     | input     | cfg_we            | cfg_data (singular_limit)
// one word accepted per cycle while the output is not stalled; stages: 2 squaring, 31 square root,
// 1 operand select, 30 cordic, 1 rounding stage
// reset clears all valid bits and sets singular_limit to 1
// the whole pipeline holds while the output word is stalled
module rotation_matrix_to_euler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [13:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  r00,
	input  logic signed [15:0]  r10,
	input  logic signed [15:0]  r11,
	input  logic signed [15:0]  r12,
	input  logic signed [15:0]  r20,
	input  logic signed [15:0]  r21,
	input  logic signed [15:0]  r22,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  angle_x,
	output logic signed [15:0]  angle_y,
	output logic signed [15:0]  angle_z,
	output logic                singular
);
	import rme_pkg::*;

	logic [13:0] singular_limit_q;
	logic        adv;

	logic        v_s1;
	mat_t        m_s1;
	logic [30:0] p0_s1, p1_s1;
	logic signed [31:0] p0w, p1w;

	logic [SQRT_STEPS:0] sq_v;
	mat_t        sq_m [0:SQRT_STEPS];
	logic [61:0] sq_n [0:SQRT_STEPS];
	logic [61:0] sq_r [0:SQRT_STEPS];

	logic [CORDIC_STEPS:0] cd_v;
	logic  cd_sing [0:CORDIC_STEPS];
	lane_t cd_x [0:CORDIC_STEPS];
	lane_t cd_y [0:CORDIC_STEPS];
	lane_t cd_z [0:CORDIC_STEPS];

	logic        out_valid_q;
	logic [29:0] sy;
	logic        sing;
	mat_t        mp;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			singular_limit_q <= 14'd1;
		end else if (cfg_we) begin
			singular_limit_q <= cfg_data;
		end
	end

	assign p0w = r00 * r00;
	assign p1w = r10 * r10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			sq_v[0] <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			sq_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1  <= '{r00, r10, r11, r12, r20, r21, r22};
			p0_s1 <= p0w[30:0];
			p1_s1 <= p1w[30:0];
			sq_m[0] <= m_s1;
			sq_n[0] <= {2'b00, 32'({1'b0, p0_s1} + {1'b0, p1_s1}), 28'd0};
			sq_r[0] <= '0;
		end
	end

	// restoring square root, one result bit per stage
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
		logic [61:0] t;
		assign t = sq_r[j] + BIT;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else if (adv) begin
				sq_v[j+1] <= sq_v[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_m[j+1] <= sq_m[j];
				if (sq_n[j] >= t) begin
					sq_n[j+1] <= sq_n[j] - t;
					sq_r[j+1] <= (sq_r[j] >> 1) + BIT;
				end else begin
					sq_n[j+1] <= sq_n[j];
					sq_r[j+1] <= sq_r[j] >> 1;
				end
			end
		end
	end

	assign sy   = sq_r[SQRT_STEPS][29:0];
	assign mp   = sq_m[SQRT_STEPS];
	assign sing = {2'b00, sy[29:14]} < {4'd0, singular_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_v[0] <= 1'b0;
		end else if (adv) begin
			cd_v[0] <= sq_v[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cd_sing[0] <= sing;
			cd_y[0] <= cordic_prep(-{{6{mp.r20[15]}}, mp.r20, 14'd0}, {6'd0, sy});
			cd_z[0] <= cordic_prep({{6{mp.r10[15]}}, mp.r10, 14'd0},
				{{6{mp.r00[15]}}, mp.r00, 14'd0});
			if (sing)
				cd_x[0] <= cordic_prep(-{{6{mp.r12[15]}}, mp.r12, 14'd0},
					{{6{mp.r11[15]}}, mp.r11, 14'd0});
			else
				cd_x[0] <= cordic_prep({{6{mp.r21[15]}}, mp.r21, 14'd0},
					{{6{mp.r22[15]}}, mp.r22, 14'd0});
		end
	end

	// vectoring cordic, three lanes side by side
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_v[i+1] <= 1'b0;
			end else if (adv) begin
				cd_v[i+1] <= cd_v[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cd_sing[i+1] <= cd_sing[i];
				cd_x[i+1]    <= cordic_step(cd_x[i], i);
				cd_y[i+1]    <= cordic_step(cd_y[i], i);
				cd_z[i+1]    <= cordic_step(cd_z[i], i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= cd_v[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_x  <= cordic_finish(cd_x[CORDIC_STEPS]);
			angle_y  <= cordic_finish(cd_y[CORDIC_STEPS]);
			angle_z  <= cd_sing[CORDIC_STEPS] ? 16'sd0 : cordic_finish(cd_z[CORDIC_STEPS]);
			singular <= cd_sing[CORDIC_STEPS];
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ test/tb_rotation_matrix_to_euler.sv @@
module tb_rotation_matrix_to_euler;
	import rme_pkg::*;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               sing;
	} euler_t;

	localparam longint PI30      = 64'sd3373259426;
	localparam longint AMAX      = 64'sd25736;
	localparam int     LATENCY   = 65;
	localparam longint MAX_CYCLE = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [13:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic signed [15:0] r00 = '0, r10 = '0, r11 = '0, r12 = '0;
	logic signed [15:0] r20 = '0, r21 = '0, r22 = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic signed [15:0] angle_x, angle_y, angle_z;
	logic        singular;

	mat_t   pending_mats[$];
	euler_t expected_angles[$];
	logic [13:0] limit_model = 14'd1;
	int     errors = 0;
	longint cycle = 0;
	bit     bursty = 1'b1;
	int     burst_left = 0;
	int     gap_left = 0;
	int     hold_left = 0;
	bit     hold_request = 1'b0;

	rotation_matrix_to_euler i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.r00(r00), .r10(r10), .r11(r11), .r12(r12), .r20(r20), .r21(r21), .r22(r22),
		.out_valid(out_valid), .out_stall(out_stall),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .singular(singular)
	);

	always #6 clk = ~clk;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_entry(int i);
		longint t[30] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
			64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
			64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
			64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
			64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004,
			64'h00000002};
		return t[i];
	endfunction

	function automatic logic signed [15:0] vector_angle(longint y, longint x);
		longint z;
		longint xs;
		longint ys;
		z = 0;
		if (y == 0)
			return (x < 0) ? AMAX[15:0] : 16'sd0;
		if (x < 0) begin
			z = (y > 0) ? PI30 : -PI30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 30; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += atan_entry(i);
			end else begin
				x -= ys;
				y += xs;
				z -= atan_entry(i);
			end
		end
		z = floor_shr(z + 65536, 17);
		if (z > AMAX)
			z = AMAX;
		if (z < -AMAX)
			z = -AMAX;
		return z[15:0];
	endfunction

	function automatic longint unsigned root_q28(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic euler_t predict_angles(mat_t m, logic [13:0] lim);
		euler_t e;
		longint unsigned sumsq;
		longint unsigned sy;
		sumsq = longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10;
		sy = root_q28(sumsq << 28);
		e.sing = (sy >> 14) < lim;
		e.ay = vector_angle(-longint'(m.r20) * 16384, longint'(sy));
		if (!e.sing) begin
			e.ax = vector_angle(longint'(m.r21) * 16384, longint'(m.r22) * 16384);
			e.az = vector_angle(longint'(m.r10) * 16384, longint'(m.r00) * 16384);
		end else begin
			e.ax = vector_angle(-longint'(m.r12) * 16384, longint'(m.r11) * 16384);
			e.az = 16'sd0;
		end
		return e;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle);
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sd0;
			3: return 16'($urandom_range(0, 6) - 3);
			4: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mat_t rotation_like();
		mat_t m;
		real a, b, c;
		a = ($urandom % 10000) * 6.2832 / 10000.0 - 3.1416;
		b = ($urandom % 10000) * 3.1416 / 10000.0 - 1.5708;
		c = ($urandom % 10000) * 6.2832 / 10000.0 - 3.1416;
		if ($urandom_range(0, 5) == 0)
			b = ($urandom_range(0, 1) ? 1.0 : -1.0) * (1.5708 - ($urandom % 100) * 1e-5);
		m.r00 = 16'($rtoi($cos(c) * $cos(b) * 16384.0));
		m.r10 = 16'($rtoi($sin(c) * $cos(b) * 16384.0));
		m.r20 = 16'($rtoi(-$sin(b) * 16384.0));
		m.r21 = 16'($rtoi($cos(b) * $sin(a) * 16384.0));
		m.r22 = 16'($rtoi($cos(b) * $cos(a) * 16384.0));
		m.r11 = 16'($rtoi($cos(a) * 16384.0));
		m.r12 = 16'($rtoi(-$sin(a) * 16384.0));
		return m;
	endfunction

	function automatic mat_t random_mat();
		mat_t m;
		if ($urandom_range(0, 3) != 0)
			return rotation_like();
		m.r00 = rand_entry(); m.r10 = rand_entry(); m.r11 = rand_entry();
		m.r12 = rand_entry(); m.r20 = rand_entry(); m.r21 = rand_entry();
		m.r22 = rand_entry();
		return m;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_angles.insert(expected_angles.size(), predict_angles(
					'{r00, r10, r11, r12, r20, r21, r22}, limit_model));
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_mats.size() > 0) begin
					{r00, r10, r11, r12, r20, r21, r22} <= pending_mats.pop_front();
					in_valid <= 1'b1;
					if (bursty) begin
						if (burst_left == 0) begin
							burst_left <= $urandom_range(1, 20);
							gap_left <= $urandom_range(0, 6);
						end else begin
							burst_left <= burst_left - 1;
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_angles.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					euler_t e;
					e = expected_angles.pop_front();
					if (angle_x !== e.ax) report_mismatch("angle_x", angle_x, e.ax);
					if (angle_y !== e.ay) report_mismatch("angle_y", angle_y, e.ay);
					if (angle_z !== e.az) report_mismatch("angle_z", angle_z, e.az);
					if (singular !== e.sing) report_mismatch("singular", singular, e.sing);
				end
			end
			if (hold_request) begin
				hold_left <= 300;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= (hold_left > 1);
			end else begin
				out_stall <= ($urandom_range(0, 99) < 25) && (cycle[8] == 1'b0);
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic drain_and_set(logic [13:0] lim);
		while (pending_mats.size() > 0 || in_valid || expected_angles.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= lim;
		limit_model = lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_mat(mat_t m);
		pending_mats.insert(pending_mats.size(), m);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			queue_mat(random_mat());
	endtask

	initial begin
		mat_t m;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		m = '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
		queue_mat(m);
		queue_mat('{default: 16'sd0});
		queue_mat('{default: 16'sh8000});
		queue_mat('{default: 16'sh7FFF});
		queue_mat('{16'sh8000, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0,
			16'sh8000});
		queue_mat('{16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sh8000, 16'sd0, 16'sd0});
		queue_mat('{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd16384, 16'sd0,
			16'sh8000});
		queue_mat('{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd100,
			16'sh8000});
		queue_mat('{16'sh8000, 16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd100,
			16'sh8000});
		queue_mat('{16'sh7FFF, 16'sh7FFF, 16'sd1, 16'sd1, 16'sh7FFF, 16'sh8000,
			16'sh7FFF});
		queue_mat('{16'sd1, 16'sd0, 16'sd3, -16'sd3, 16'sd0, 16'sd0, 16'sd0});
		drain_and_set(14'd0);
		queue_mat('{default: 16'sd0});
		queue_mat('{16'sd0, 16'sd0, 16'sd7, 16'sd7, 16'sd1, 16'sd1, 16'sd1});
		queue_random(80);
		drain_and_set(14'h3FFF);
		queue_mat('{16'sh7FFF, 16'sh7FFF, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5});
		queue_random(120);
		drain_and_set(14'd16);
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		queue_random(150);
		drain_and_set(14'd1638);
		bursty = 1'b0;
		queue_random(150);
		drain_and_set(14'($urandom));
		bursty = 1'b1;
		queue_random(150);
		drain_and_set(14'd1);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
